// ===== hdl/iaf_pkg.sv =====
// ----------------------------------------------------------------------------
// iaf_pkg
// Format codes, character constants and digit helpers for the integer to
// ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package iaf_pkg;

  typedef logic [2:0]  op_t;
  typedef logic [3:0]  nibble_t;
  typedef logic [2:0]  pos_t;
  typedef logic [16:0] weight_t;

  localparam op_t OP_HEX8  = 3'd0;
  localparam op_t OP_HEX16 = 3'd1;
  localparam op_t OP_UDEC8 = 3'd2;
  localparam op_t OP_SDEC8 = 3'd3;
  localparam op_t OP_UDEC16 = 3'd4;
  localparam op_t OP_SDEC16 = 3'd5;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LETTER = 8'h37;  // 'A' - 10
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  localparam pos_t POS_UNITS = 3'd0;
  localparam pos_t POS_TENS  = 3'd1;
  localparam pos_t POS_HUND  = 3'd2;
  localparam pos_t POS_THOU  = 3'd3;
  localparam pos_t POS_TTHOU = 3'd4;

  function automatic weight_t dec_weight(input pos_t pos);
    weight_t w;
    case (pos)
      POS_TTHOU: w = 17'd10000;
      POS_THOU:  w = 17'd1000;
      POS_HUND:  w = 17'd100;
      POS_TENS:  w = 17'd10;
      default:   w = 17'd1;
    endcase
    return w;
  endfunction

  // Digit of rem at the given decimal position; rem is below ten times the weight.
  function automatic nibble_t dec_digit(input logic [15:0] rem, input pos_t pos);
    weight_t w;
    nibble_t d;
    w = dec_weight(pos);
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, rem} >= 17'(k) * w) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

  function automatic logic [7:0] hex_char(input nibble_t nib);
    logic [7:0] c;
    if (nib > 4'd9) begin
      c = CH_LETTER + {4'd0, nib};
    end else begin
      c = CH_ZERO + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Turns one integer into a run of ASCII hex or decimal characters.
// ----------------------------------------------------------------------------
// An item has 2 characters for hex8, 4 for hex16, 1 to 5 for unsigned
// decimal and 1 to 6 for signed decimal. The character generator emits one
// character per cycle from a working register, so a new transaction is
// accepted in the cycle that forms the last character of the current one,
// and runs follow each other with no gap. The first character of a run is
// formed from the working register and then registered onto the outputs.
// Each character is held for exactly one cycle with strobe high; the receiver
// cannot stall. Format codes 6 and 7 are accepted and produce no output.
`default_nettype none

module integer_to_ascii_formatter (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire iaf_pkg::op_t    operation,
  input  wire logic [15:0]     value,
  output logic                 strobe,
  output logic [7:0]           character,
  output logic                 last
);

  // working register
  logic              act;
  logic              hexm;
  logic              minus;
  iaf_pkg::pos_t     idx;
  logic [15:0]       rem;

  logic              accept;
  logic              op_valid;
  logic              cur_last;
  logic [7:0]        cur_char;
  iaf_pkg::nibble_t  digit;
  logic [20:0]       prod;
  logic [15:0]       rem_next;

  logic              ld_hex;
  logic              ld_neg;
  logic [15:0]       ld_mag;
  logic [15:0]       ld_rem;
  iaf_pkg::pos_t     ld_idx;
  logic [7:0]        neg8;
  logic [15:0]       neg16;

  // load decode
  always_comb begin
    op_valid = 1'b1;
    ld_hex   = 1'b0;
    ld_neg   = 1'b0;
    neg8     = 8'd0 - value[7:0];
    neg16    = 16'd0 - value;
    ld_mag   = {8'd0, value[7:0]};
    case (operation)
      iaf_pkg::OP_HEX8: begin
        ld_hex = 1'b1;
      end
      iaf_pkg::OP_HEX16: begin
        ld_hex = 1'b1;
        ld_mag = value;
      end
      iaf_pkg::OP_UDEC8: begin
        ld_mag = {8'd0, value[7:0]};
      end
      iaf_pkg::OP_SDEC8: begin
        ld_neg = value[7];
        ld_mag = value[7] ? {8'd0, neg8} : {8'd0, value[7:0]};
      end
      iaf_pkg::OP_UDEC16: begin
        ld_mag = value;
      end
      iaf_pkg::OP_SDEC16: begin
        ld_neg = value[15];
        ld_mag = value[15] ? neg16 : value;
      end
      default: begin
        op_valid = 1'b0;
      end
    endcase

    ld_rem = ld_mag;
    if (ld_hex) begin
      ld_idx = (operation == iaf_pkg::OP_HEX16) ? 3'd3 : 3'd1;
    end else if (ld_mag >= 16'd10000) begin
      ld_idx = iaf_pkg::POS_TTHOU;
    end else if (ld_mag >= 16'd1000) begin
      ld_idx = iaf_pkg::POS_THOU;
    end else if (ld_mag >= 16'd100) begin
      ld_idx = iaf_pkg::POS_HUND;
    end else if (ld_mag >= 16'd10) begin
      ld_idx = iaf_pkg::POS_TENS;
    end else begin
      ld_idx = iaf_pkg::POS_UNITS;
    end
  end

  // character generation
  always_comb begin
    digit    = iaf_pkg::dec_digit(rem, idx);
    prod     = 21'(digit) * 21'(iaf_pkg::dec_weight(idx));
    rem_next = rem - prod[15:0];
    cur_last = !minus && (idx == iaf_pkg::POS_UNITS);
    if (minus) begin
      cur_char = iaf_pkg::CH_MINUS;
    end else if (hexm) begin
      cur_char = iaf_pkg::hex_char(rem[{idx[1:0], 2'b00} +: 4]);
    end else begin
      cur_char = iaf_pkg::CH_ZERO + {4'd0, digit};
    end
  end

  assign busy   = act && !cur_last;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      act    <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= act;
      if (act && !cur_last) begin
        if (minus) begin
          minus <= 1'b0;
        end else begin
          idx <= idx - 3'd1;
          if (!hexm) begin
            rem <= rem_next;
          end
        end
      end else if (accept && op_valid) begin
        act   <= 1'b1;
        hexm  <= ld_hex;
        minus <= ld_neg;
        idx   <= ld_idx;
        rem   <= ld_rem;
      end else begin
        act <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    character <= cur_char;
    last      <= cur_last;
  end

  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    act |=> strobe)
    else $error("active character not presented");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && character == iaf_pkg::CH_MINUS) |-> !last)
    else $error("minus sign ended a run");

  a_accept_output: assert property (@(posedge clk) disable iff (rst)
    (accept && op_valid) |-> ##2 strobe)
    else $error("accepted transaction produced no character");

endmodule

`default_nettype wire
